/* rtl/mcr_pkg.sv */
// Shared types, widths and helper functions for the midpoint circle rasterizer.
package mcr_pkg;

    // Field widths of the command and result words
    localparam int COORD_W  = 7;
    localparam int RADIUS_W = 6;
    localparam int COLOR_W  = 8;
    localparam int CANVAS_W = 8;
    localparam int LANES    = 8;
    localparam int PIX_W    = LANES * COORD_W;
    localparam int POS_W    = COORD_W + 2;

    // Bus widths (tdata padded to whole bytes)
    localparam int CMD_BITS   = 2 * COORD_W + RADIUS_W + COLOR_W;
    localparam int S_DATA_W   = ((CMD_BITS + 7) / 8) * 8;
    localparam int M_DATA_W   = 2 * PIX_W + LANES + COLOR_W;

    // Defaults for top-level parameters
    localparam int DEF_MAX_CANVAS = 128;
    localparam int DEF_MAX_RADIUS = 63;
    localparam int CMD_QUEUE_DEPTH = 2;

    // One circle command after radius clamping
    typedef struct packed {
        logic [COORD_W-1:0]  center_x;
        logic [COORD_W-1:0]  center_y;
        logic [RADIUS_W-1:0] radius;
        logic [COLOR_W-1:0]  color;
    } mcr_cmd_t;

    // One result word: eight mirrored points of an iteration
    typedef struct packed {
        logic             last_step;
        logic [COLOR_W-1:0] pixel_color;
        logic [LANES-1:0] in_bounds_mask;
        logic [PIX_W-1:0] pixel_rows;
        logic [PIX_W-1:0] pixel_columns;
    } mcr_result_t;

    // Point coordinate inside [0, lim)
    function automatic logic in_canvas(logic signed [POS_W-1:0] v,
                                       logic [CANVAS_W-1:0] lim);
        return !v[POS_W-1] && (v[CANVAS_W-1:0] < lim);
    endfunction

    // Expand a lane mask to a per-bit mask over the packed coordinates
    function automatic logic [PIX_W-1:0] spread_mask(logic [LANES-1:0] m);
        logic [PIX_W-1:0] s;
        s = '0;
        for (int k = 0; k < LANES; k++) begin
            s[k*COORD_W +: COORD_W] = {COORD_W{m[k]}};
        end
        return s;
    endfunction

endpackage

/* rtl/mcr_cmd_queue.sv */
// Small command queue between the front end and the rasterizing engine.
module mcr_cmd_queue
    import mcr_pkg::*;
#(
    parameter int DEPTH = CMD_QUEUE_DEPTH,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  mcr_cmd_t push_data,
    output logic     full,
    input  logic     pop,
    output mcr_cmd_t pop_data,
    output logic     not_empty
);

    mcr_cmd_t        entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/mcr_front.sv */
// Front end: takes command words and the canvas register, clamps them, feeds the queue.
module mcr_front
    import mcr_pkg::*;
#(
    parameter int MAX_CANVAS = DEF_MAX_CANVAS,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    localparam int LW = $clog2(MAX_CANVAS + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    // command word
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    // canvas size register
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CANVAS_W-1:0] cfg_data,
    // queue side
    output logic                q_push,
    output mcr_cmd_t            q_data,
    input  logic                q_full,
    output logic [LW-1:0]       canvas_lim
);

    logic [LW-1:0]       canvas_reg, canvas_next;
    logic [RADIUS_W-1:0] radius_in;

    assign cfg_ready  = 1'b1;
    assign canvas_lim = canvas_reg;

    // Canvas size, oversize values saturate at the largest canvas
    always_comb
    begin
        canvas_next = canvas_reg;
        if (cfg_valid)
        begin
            canvas_next = (cfg_data > CANVAS_W'(MAX_CANVAS)) ? LW'(MAX_CANVAS)
                                                             : LW'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_reg <= LW'(MAX_CANVAS);
        end
        else
        begin
            canvas_reg <= canvas_next;
        end
    end

    // Unpack the command word and clamp the radius
    assign radius_in = s_tdata[2*COORD_W +: RADIUS_W];
    assign s_tready  = !q_full;
    assign q_push    = s_tvalid && !q_full;

    always_comb
    begin
        q_data.center_x = s_tdata[0 +: COORD_W];
        q_data.center_y = s_tdata[COORD_W +: COORD_W];
        q_data.radius   = (radius_in > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS)
                                                              : radius_in;
        q_data.color    = s_tdata[2*COORD_W + RADIUS_W +: COLOR_W];
    end

endmodule

/* rtl/mcr_engine.sv */
// Back end: steps the midpoint circle loop, one octant-mirrored result word per cycle while m_ready is high.
module mcr_engine
    import mcr_pkg::*;
#(
    parameter int MAX_CANVAS = DEF_MAX_CANVAS,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    localparam int LW = $clog2(MAX_CANVAS + 1),
    localparam int RW = $clog2(MAX_RADIUS + 1),
    localparam int XW = RW + 1,
    localparam int EW = RW + 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [LW-1:0] canvas_lim,
    // queue side
    input  logic          q_not_empty,
    input  mcr_cmd_t      q_data,
    output logic          q_pop,
    // result side
    output logic          m_valid,
    input  logic          m_ready,
    output mcr_result_t   m_result
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                 state_reg;
    logic                   out_valid_reg;
    mcr_result_t            out_reg;
    logic signed [XW-1:0]   x_reg, y_reg;
    logic signed [EW-1:0]   err_reg;
    logic [COORD_W-1:0]     cx_reg, cy_reg;
    logic [COLOR_W-1:0]     color_reg;

    logic                   load;
    logic signed [XW-1:0]   x_next, y_next, x_start;
    logic signed [EW-1:0]   err_next, ye, dxy;
    logic                   last_next;
    logic signed [POS_W-1:0] cxe, cye, xe, yv;
    logic signed [POS_W-1:0] pc [LANES];
    logic signed [POS_W-1:0] pr [LANES];
    logic [PIX_W-1:0]       cols, rows;
    logic [LANES-1:0]       mask;
    logic [CANVAS_W-1:0]    lim;

    assign q_pop    = (state_reg == ST_IDLE) && q_not_empty;
    assign load     = (state_reg == ST_RUN) && (!out_valid_reg || m_ready);
    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;
    assign lim      = CANVAS_W'(canvas_lim);
    assign x_start  = signed'({1'b0, q_data.radius[RW-1:0]});

    // Iterator update: y advances, x steps down when the error is not negative
    always_comb
    begin
        y_next = y_reg + XW'(1);
        ye     = EW'(y_next);
        x_next = x_reg;
        dxy    = ye;
        if (!err_reg[EW-1])
        begin
            x_next = x_reg - XW'(1);
            dxy    = ye - EW'(x_next);
        end
        err_next  = err_reg + (dxy <<< 1) + EW'(1);
        last_next = (x_next < y_next);
    end

    // Eight mirrored points and canvas clipping
    always_comb
    begin
        cxe = signed'({2'b00, cx_reg});
        cye = signed'({2'b00, cy_reg});
        xe  = POS_W'(x_reg);
        yv  = POS_W'(y_reg);
        pc[0] = cxe + xe;  pr[0] = cye + yv;
        pc[1] = cxe + yv;  pr[1] = cye + xe;
        pc[2] = cxe - xe;  pr[2] = cye + yv;
        pc[3] = cxe - yv;  pr[3] = cye + xe;
        pc[4] = cxe - xe;  pr[4] = cye - yv;
        pc[5] = cxe - yv;  pr[5] = cye - xe;
        pc[6] = cxe + xe;  pr[6] = cye - yv;
        pc[7] = cxe + yv;  pr[7] = cye - xe;
        cols = '0;
        rows = '0;
        mask = '0;
        for (int k = 0; k < LANES; k++)
        begin
            if (in_canvas(pc[k], lim) && in_canvas(pr[k], lim))
            begin
                mask[k] = 1'b1;
                cols[k*COORD_W +: COORD_W] = pc[k][COORD_W-1:0];
                rows[k*COORD_W +: COORD_W] = pr[k][COORD_W-1:0];
            end
        end
    end

    // Sequencer, iterator registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            err_reg       <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            color_reg     <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_not_empty)
                    begin
                        cx_reg    <= q_data.center_x;
                        cy_reg    <= q_data.center_y;
                        color_reg <= q_data.color;
                        x_reg     <= x_start;
                        y_reg     <= '0;
                        err_reg   <= EW'(1) - EW'(x_start);
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (load)
                    begin
                        out_reg.pixel_columns  <= cols;
                        out_reg.pixel_rows     <= rows;
                        out_reg.in_bounds_mask <= mask;
                        out_reg.pixel_color    <= color_reg;
                        out_reg.last_step      <= last_next;
                        x_reg   <= x_next;
                        y_reg   <= y_next;
                        err_reg <= err_next;
                        if (last_next)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // The loop only runs while x has not dropped below y
    a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (x_reg >= y_reg))
        else $error("engine running with x below y");

    // Issuing the final word ends the circle
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (load && last_next) |=> (state_reg == ST_IDLE))
        else $error("engine kept running after last word");

    // Clipped lanes carry zero coordinates
    a_clip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (((out_reg.pixel_columns | out_reg.pixel_rows)
                            & ~spread_mask(out_reg.in_bounds_mask)) == '0))
        else $error("clipped lane has nonzero coordinates");

    // No new command is taken while a circle is in progress
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> !q_pop)
        else $error("command popped during a circle");
`endif

endmodule

/* rtl/midpoint_circle_rasterizer_core.sv */
// The first result word of a command is registered after it passes a queue entry, the engine's
// iterator registers and its output register. A radius r circle yields N = (iterations of x >= y)
// words, one per cycle while m_tready is high; the next command is loaded in the idle state after.
// A two-entry command queue keeps accepting words, until it is full, while the engine steps a circle.
// Reset (async, active low) clears control state and sets the canvas size to MAX_CANVAS.
module midpoint_circle_rasterizer_core
    import mcr_pkg::*;
#(
    parameter int MAX_CANVAS = DEF_MAX_CANVAS,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // center_x[6:0], center_y[13:7], radius[19:14], color[27:20], zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // pixel_columns[55:0], pixel_rows[111:56], in_bounds_mask[119:112],
    // pixel_color[127:120]
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CANVAS_W-1:0] cfg_data
);

    localparam int LW = $clog2(MAX_CANVAS + 1);

    logic          q_push, q_full, q_pop, q_not_empty;
    mcr_cmd_t      q_in, q_out;
    logic [LW-1:0] canvas_lim;
    mcr_result_t   result;

    mcr_front #(
        .MAX_CANVAS (MAX_CANVAS),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .q_push     (q_push),
        .q_data     (q_in),
        .q_full     (q_full),
        .canvas_lim (canvas_lim)
    );

    mcr_cmd_queue #(
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .not_empty (q_not_empty)
    );

    mcr_engine #(
        .MAX_CANVAS (MAX_CANVAS),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .canvas_lim  (canvas_lim),
        .q_not_empty (q_not_empty),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_result    (result)
    );

    // Result word packing
    assign m_tdata = {result.pixel_color, result.in_bounds_mask,
                      result.pixel_rows, result.pixel_columns};
    assign m_tlast = result.last_step;

endmodule
